// ===== hdl/ora_pkg.sv =====
// ----------------------------------------------------------------------------
// ora_pkg
// Shared types and fixed field widths for the outlier-rejecting sample average.
// ----------------------------------------------------------------------------
package ora_pkg;

   // result field widths, fixed by the interface
   localparam int SAMPLE_IN_W = 12;
   localparam int MEAN_W      = 12;
   localparam int VAR_W       = 23;
   localparam int COUNT_W     = 5;

   // saturation limits of the result fields
   localparam logic [MEAN_W-1:0]  MEAN_MAX  = {MEAN_W{1'b1}};
   localparam logic [VAR_W-1:0]   VAR_MAX   = {VAR_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // statistics engine sequencer
   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SUM,
      ENG_MEAN_DIV,
      ENG_VAR,
      ENG_VAR_DIV,
      ENG_KEEP,
      ENG_FMEAN_DIV,
      ENG_DONE
   } eng_state_type;

   // control from the front end to the engine
   typedef struct packed {
      logic start;
      logic result_taken;
   } eng_ctrl_type;

   // status from the engine to the front end
   typedef struct packed {
      logic busy;
      logic result_valid;
   } eng_status_type;

   // one result beat
   typedef struct packed {
      logic [MEAN_W-1:0]  filtered_mean;
      logic [MEAN_W-1:0]  plain_mean;
      logic [VAR_W-1:0]   sample_variance;
      logic [COUNT_W-1:0] kept_count;
   } result_type;

endpackage

// ===== hdl/ora_sample_ram.sv =====
// ----------------------------------------------------------------------------
// ora_sample_ram
// Burst sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ora_sample_ram #(
   parameter int DEPTH  = 20,
   parameter int WIDTH  = 12,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write incoming samples
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // register read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ora_divider.sv =====
// ----------------------------------------------------------------------------
// ora_divider
// Restoring divider, one quotient bit per cycle. Divide by zero gives all ones.
// ----------------------------------------------------------------------------
module ora_divider #(
   parameter int NUM_W = 29,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   shifted;
   logic             fits;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   // one shift-and-subtract step
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
      quo_in  = {quo_ff[NUM_W-2:0], fits};
   end

   // step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // load operands, then shift the quotient in
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/ora_engine.sv =====
// ----------------------------------------------------------------------------
// ora_engine
// Three read passes over the sample store (sum, squared deviation, clipped
// sum). Division by the burst length is a reciprocal multiply; the clipped
// mean uses a serial divider.
// ----------------------------------------------------------------------------
module ora_engine #(
   parameter int SAMPLE_COUNT = 20,
   parameter int SAMPLE_BITS  = 12,
   parameter int ADDR_W       = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ora_pkg::eng_ctrl_type    ctrl,
   output ora_pkg::eng_status_type  status,
   output ora_pkg::result_type      result,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [SAMPLE_BITS-1:0]   rd_data
);

   localparam int CW          = $clog2(SAMPLE_COUNT + 1);
   localparam int SQ_W        = 2 * SAMPLE_BITS + CW;
   localparam int KS_W        = SAMPLE_BITS + CW;
   localparam int MW          = ora_pkg::MEAN_W;
   localparam int VW          = ora_pkg::VAR_W;
   localparam int KW          = ora_pkg::COUNT_W;
   localparam logic [CW-1:0] COUNT_DEN = CW'(SAMPLE_COUNT);
   // floor(x / SAMPLE_COUNT) == (x * RECIP) >> RECIP_SHIFT for every x < 2**SQ_W
   localparam int RECIP_SHIFT = SQ_W + CW;
   localparam int RECIP_W     = SQ_W + 2;
   localparam int PROD_W      = SQ_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
      + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

   ora_pkg::eng_state_type state_ff, state_in;

   logic [CW-1:0]            cnt_ff;
   logic                     v1_ff;
   logic                     v2_ff;
   logic [SAMPLE_BITS-1:0]   samp_ff;
   logic [2*SAMPLE_BITS-1:0] sq_ff;
   logic [SQ_W-1:0]          acc_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [KS_W-1:0]          ksum_ff;
   logic [CW-1:0]            kept_ff;
   logic [SAMPLE_BITS-1:0]   mean_ff;
   logic [2*SAMPLE_BITS-1:0] var_ff;
   logic [SAMPLE_BITS-1:0]   fmean_ff;

   logic                     pass_start;
   logic                     pass_done;
   logic                     div_start;
   logic [KS_W-1:0]          div_num;
   logic [CW-1:0]            div_den;
   logic                     div_done;
   logic [KS_W-1:0]          div_quo;
   logic [SAMPLE_BITS-1:0]   diff;

   ora_divider #(
      .NUM_W (KS_W),
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign pass_done = (cnt_ff == COUNT_DEN) && !v1_ff && !v2_ff;
   assign rd_addr   = cnt_ff[ADDR_W-1:0];

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ora_pkg::ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence passes and divisions
   always_comb begin
      state_in   = state_ff;
      pass_start = 1'b0;
      div_start  = 1'b0;
      div_num    = ksum_ff;
      div_den    = kept_ff;
      rd_en      = 1'b0;
      unique case (state_ff)
         ora_pkg::ENG_IDLE: begin
            if (ctrl.start) begin
               pass_start = 1'b1;
               state_in   = ora_pkg::ENG_SUM;
            end
         end
         ora_pkg::ENG_SUM: begin
            rd_en = cnt_ff != COUNT_DEN;
            if (pass_done) begin
               state_in = ora_pkg::ENG_MEAN_DIV;
            end
         end
         ora_pkg::ENG_MEAN_DIV: begin
            pass_start = 1'b1;
            state_in   = ora_pkg::ENG_VAR;
         end
         ora_pkg::ENG_VAR: begin
            rd_en = cnt_ff != COUNT_DEN;
            if (pass_done) begin
               state_in = ora_pkg::ENG_VAR_DIV;
            end
         end
         ora_pkg::ENG_VAR_DIV: begin
            pass_start = 1'b1;
            state_in   = ora_pkg::ENG_KEEP;
         end
         ora_pkg::ENG_KEEP: begin
            rd_en = cnt_ff != COUNT_DEN;
            if (pass_done) begin
               div_start = 1'b1;
               state_in  = ora_pkg::ENG_FMEAN_DIV;
            end
         end
         ora_pkg::ENG_FMEAN_DIV: begin
            if (div_done) begin
               state_in = ora_pkg::ENG_DONE;
            end
         end
         ora_pkg::ENG_DONE: begin
            if (ctrl.result_taken) begin
               state_in = ora_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = ora_pkg::ENG_IDLE;
         end
      endcase
   end

   // advance the read address and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         if (pass_start) begin
            cnt_ff <= '0;
         end else if (rd_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // absolute deviation of the read sample from the mean
   assign diff = (rd_data >= mean_ff) ? rd_data - mean_ff : mean_ff - rd_data;

   // square the deviation and hold the sample beside it
   always_ff @(posedge clock) begin
      if (v1_ff) begin
         samp_ff <= rd_data;
         sq_ff   <= (2*SAMPLE_BITS)'(diff) * (2*SAMPLE_BITS)'(diff);
      end
   end

   // accumulate per pass
   always_ff @(posedge clock) begin
      if (pass_start) begin
         acc_ff  <= '0;
         ksum_ff <= '0;
         kept_ff <= '0;
      end else if (v2_ff) begin
         case (state_ff)
            ora_pkg::ENG_SUM: acc_ff <= acc_ff + SQ_W'(samp_ff);
            ora_pkg::ENG_VAR: acc_ff <= acc_ff + SQ_W'(sq_ff);
            ora_pkg::ENG_KEEP: begin
               if (sq_ff <= var_ff) begin
                  ksum_ff <= ksum_ff + KS_W'(samp_ff);
                  kept_ff <= kept_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // multiply the pass total by the reciprocal of the burst length
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(acc_ff) * PROD_W'(RECIP);
   end

   // capture quotients
   always_ff @(posedge clock) begin
      case (state_ff)
         ora_pkg::ENG_MEAN_DIV: mean_ff <= prod_ff[RECIP_SHIFT +: SAMPLE_BITS];
         ora_pkg::ENG_VAR_DIV:  var_ff  <= prod_ff[RECIP_SHIFT +: 2*SAMPLE_BITS];
         ora_pkg::ENG_FMEAN_DIV: begin
            if (div_done) begin
               fmean_ff <= (kept_ff == '0) ? mean_ff : div_quo[SAMPLE_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // saturate into the result fields
   always_comb begin
      result.filtered_mean = (64'(fmean_ff) > 64'(ora_pkg::MEAN_MAX))
                           ? ora_pkg::MEAN_MAX : MW'(fmean_ff);
      result.plain_mean    = (64'(mean_ff) > 64'(ora_pkg::MEAN_MAX))
                           ? ora_pkg::MEAN_MAX : MW'(mean_ff);
      result.sample_variance = (64'(var_ff) > 64'(ora_pkg::VAR_MAX))
                             ? ora_pkg::VAR_MAX : VW'(var_ff);
      result.kept_count    = (64'(kept_ff) > 64'(ora_pkg::COUNT_MAX))
                           ? ora_pkg::COUNT_MAX : KW'(kept_ff);
   end

   assign status.busy         = state_ff != ora_pkg::ENG_IDLE;
   assign status.result_valid = state_ff == ora_pkg::ENG_DONE;

endmodule

// ===== hdl/outlier_rejecting_sample_average_core.sv =====
// ----------------------------------------------------------------------------
// outlier_rejecting_sample_average_core
// Collects a burst of samples, then reports the one-sigma clipped mean.
// ----------------------------------------------------------------------------
// Input: one sample beat per cycle while a burst fills; after the last sample
// req_stall stays high for three read passes, two reciprocal multiplies and a divide,
// then until the engine hands its result to the output register. The result beat
// appears as req_stall falls; both wait while an earlier result beat is held by
// rsp_stall. Reset: synchronous, clears fill count, engine and output valid, sets
// discard state; store not cleared.
module outlier_rejecting_sample_average_core #(
   parameter int SAMPLE_COUNT = 20,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ora_pkg::SAMPLE_IN_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ora_pkg::MEAN_W-1:0]    rsp_filtered_mean,
   output logic [ora_pkg::MEAN_W-1:0]    rsp_plain_mean,
   output logic [ora_pkg::VAR_W-1:0]     rsp_sample_variance,
   output logic [ora_pkg::COUNT_W-1:0]   rsp_kept_count,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data
);

   localparam int CW     = $clog2(SAMPLE_COUNT + 1);
   localparam int ADDR_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam logic [CW-1:0] FILL_LAST = CW'(SAMPLE_COUNT - 1);

   logic                    discard_first_ff;
   logic                    discard_pending_ff;
   logic [CW-1:0]           fill_ff;
   logic                    rsp_valid_ff;
   ora_pkg::result_type     rsp_data_ff;

   logic                    req_beat;
   logic                    store;
   logic                    slot_free;
   logic [SAMPLE_BITS-1:0]  sample;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [SAMPLE_BITS-1:0]  rd_data;
   ora_pkg::eng_ctrl_type   eng_ctrl;
   ora_pkg::eng_status_type eng_status;
   ora_pkg::result_type     eng_result;

   assign req_stall = eng_status.busy;
   assign req_beat  = req_valid && !req_stall;
   assign store     = req_beat && !(discard_pending_ff && discard_first_ff);
   assign sample    = SAMPLE_BITS'(req_sample);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign eng_ctrl.start        = store && (fill_ff == FILL_LAST);
   assign eng_ctrl.result_taken = eng_status.result_valid && slot_free;

   // burst bookkeeping and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         discard_first_ff   <= 1'b1;
         discard_pending_ff <= 1'b1;
         fill_ff            <= '0;
      end else begin
         if (csr_write_enable) begin
            discard_first_ff <= csr_write_data;
         end
         if (req_beat && discard_pending_ff) begin
            discard_pending_ff <= 1'b0;
         end
         if (store) begin
            if (fill_ff == FILL_LAST) begin
               fill_ff            <= '0;
               discard_pending_ff <= 1'b1;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   ora_sample_ram #(
      .DEPTH  (SAMPLE_COUNT),
      .WIDTH  (SAMPLE_BITS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ora_engine #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .ADDR_W       (ADDR_W)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (eng_ctrl),
      .status  (eng_status),
      .result  (eng_result),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_ctrl.result_taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (eng_ctrl.result_taken) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_mean   = rsp_data_ff.filtered_mean;
   assign rsp_plain_mean      = rsp_data_ff.plain_mean;
   assign rsp_sample_variance = rsp_data_ff.sample_variance;
   assign rsp_kept_count      = rsp_data_ff.kept_count;

endmodule

// ===== hdl/ora_checker.sv =====
// ----------------------------------------------------------------------------
// ora_checker
// Port-level checks on the outlier-rejecting sample average core.
// ----------------------------------------------------------------------------
module ora_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [ora_pkg::MEAN_W-1:0]      rsp_filtered_mean,
   input logic [ora_pkg::MEAN_W-1:0]      rsp_plain_mean,
   input logic [ora_pkg::VAR_W-1:0]       rsp_sample_variance,
   input logic [ora_pkg::COUNT_W-1:0]     rsp_kept_count
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_mean)
         && $stable(rsp_plain_mean) && $stable(rsp_sample_variance)
         && $stable(rsp_kept_count))
      else $error("stalled result beat changed");

   // at least one sample always passes the deviation test
   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kept_count != '0)
      else $error("result with zero kept samples");

   // reset leaves the block idle and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // the engine releases the input only after handing over its result
   a_release_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(req_stall) |-> rsp_valid)
      else $error("input released without a result beat");

endmodule

bind outlier_rejecting_sample_average_core ora_checker u_ora_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_filtered_mean   (rsp_filtered_mean),
   .rsp_plain_mean      (rsp_plain_mean),
   .rsp_sample_variance (rsp_sample_variance),
   .rsp_kept_count      (rsp_kept_count)
);

// ===== verif/outlier_rejecting_sample_average_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// outlier_rejecting_sample_average_core_test
// Self-checking bench for the one-sigma clipped mean core. A short stimulus
// table hits the field extremes and the discard register cases. Random bursts
// with uniform, clustered, extreme and flat content follow, and both sides
// idle at random. Every result beat is checked against a cycle-free model
// of the burst statistics.
// ----------------------------------------------------------------------------
module outlier_rejecting_sample_average_core_test;

   localparam int SAMP_W         = ora_pkg::SAMPLE_IN_W;
   localparam int MEAN_W         = ora_pkg::MEAN_W;
   localparam int VAR_W          = ora_pkg::VAR_W;
   localparam int COUNT_W        = ora_pkg::COUNT_W;
   localparam int BURST_LEN      = 20;
   localparam int SAMPLE_MAX     = (1 << SAMP_W) - 1;
   localparam int ENGINE_SETTLE  = 200;
   localparam int LONG_HOLD      = 600;
   localparam int RANDOM_SAMPLES = 1650;
   localparam int TAIL_SAMPLES   = 150;

   typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {MIX_UNIFORM, MIX_CLUSTER, MIX_EXTREME, MIX_FLAT} mix_type;

   typedef struct {
      row_kind_type kind;
      logic [SAMP_W-1:0] value;
      int reps;
      bit has_exp;
      ora_pkg::result_type exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [SAMP_W-1:0] req_sample = '0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [MEAN_W-1:0] rsp_filtered_mean;
   logic [MEAN_W-1:0] rsp_plain_mean;
   logic [VAR_W-1:0] rsp_sample_variance;
   logic [COUNT_W-1:0] rsp_kept_count;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   // model state of the core
   logic [SAMP_W-1:0] burst_store [BURST_LEN];
   int burst_fill;
   bit drop_armed;
   bit drop_first_cfg;

   ora_pkg::result_type pending_results[$];
   int mismatch_count = 0;
   int gap_rate = 0;
   bit quiet_tail = 1'b0;
   bit hold_request = 1'b0;

   stim_row_type directed_rows [0:9];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   outlier_rejecting_sample_average_core #(
      .SAMPLE_COUNT(BURST_LEN),
      .SAMPLE_BITS(SAMP_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_filtered_mean(rsp_filtered_mean),
      .rsp_plain_mean(rsp_plain_mean),
      .rsp_sample_variance(rsp_sample_variance),
      .rsp_kept_count(rsp_kept_count),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   function automatic longint unsigned sq_distance(logic [SAMP_W-1:0] s,
                                                   longint unsigned mean);
      longint unsigned d;
      d = (s >= mean) ? s - mean : mean - s;
      return d * d;
   endfunction

   // advance the burst model by one sample; done marks a finished burst
   task automatic absorb_sample(input logic [SAMP_W-1:0] s, output bit stored,
                                output bit done, output ora_pkg::result_type r);
      longint unsigned total, sq_total, keep_total, keep_n, mean_v, var_v, fmean_v;
      total = 0;
      sq_total = 0;
      keep_total = 0;
      keep_n = 0;
      stored = 1'b0;
      done = 1'b0;
      r = '0;
      if (drop_armed) begin
         drop_armed = 1'b0;
         if (drop_first_cfg) return;
      end
      stored = 1'b1;
      if (burst_fill >= BURST_LEN) burst_fill = 0;
      burst_store[burst_fill] = s;
      burst_fill++;
      if (burst_fill < BURST_LEN) return;

      // three passes: mean, variance, clipped mean
      foreach (burst_store[i]) total += burst_store[i];
      mean_v = total / BURST_LEN;
      foreach (burst_store[i]) sq_total += sq_distance(burst_store[i], mean_v);
      var_v = sq_total / BURST_LEN;
      foreach (burst_store[i]) begin
         if (sq_distance(burst_store[i], mean_v) <= var_v) begin
            keep_total += burst_store[i];
            keep_n++;
         end
      end
      fmean_v = (keep_n != 0) ? keep_total / keep_n : mean_v;

      r.filtered_mean   = (fmean_v > ora_pkg::MEAN_MAX) ? ora_pkg::MEAN_MAX
                                                        : fmean_v[MEAN_W-1:0];
      r.plain_mean      = (mean_v > ora_pkg::MEAN_MAX) ? ora_pkg::MEAN_MAX
                                                       : mean_v[MEAN_W-1:0];
      r.sample_variance = (var_v > ora_pkg::VAR_MAX) ? ora_pkg::VAR_MAX
                                                     : var_v[VAR_W-1:0];
      r.kept_count      = (keep_n > ora_pkg::COUNT_MAX) ? ora_pkg::COUNT_MAX
                                                        : keep_n[COUNT_W-1:0];
      burst_fill = 0;
      drop_armed = 1'b1;
      done = 1'b1;
   endtask

   function automatic logic [SAMP_W-1:0] draw_sample(mix_type mode, int center,
                                                     int spread);
      int v;
      case (mode)
         MIX_CLUSTER: begin
            if ($urandom_range(0, 7) == 0) v = int'($urandom_range(0, SAMPLE_MAX));
            else v = center + int'($urandom_range(0, 2 * spread)) - spread;
         end
         MIX_EXTREME: begin
            case ($urandom_range(0, 3))
               0: v = 0;
               1: v = SAMPLE_MAX;
               2: v = (SAMPLE_MAX + 1) / 2;
               default: v = (SAMPLE_MAX + 1) / 2 - 1;
            endcase
         end
         MIX_FLAT: v = center + int'($urandom_range(0, 1));
         default: v = int'($urandom_range(0, SAMPLE_MAX));
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v[SAMP_W-1:0];
   endfunction

   // offer one sample beat, then record the expected result if it ends a burst
   task automatic send_sample(input logic [SAMP_W-1:0] value, input bit use_typed,
                              input ora_pkg::result_type typed, output bit stored);
      ora_pkg::result_type predicted;
      bit done;
      int gap;
      if (!quiet_tail && gap_rate != 0 && $urandom_range(0, 9) < gap_rate) begin
         gap = $urandom_range(1, 10);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      absorb_sample(value, stored, done, predicted);
      if (done) pending_results.push_back(use_typed ? typed : predicted);
   endtask

   // drop valid, drain every expected result, then let the engine go quiet
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (ENGINE_SETTLE) @(posedge clock);
   endtask

   task automatic write_discard(input bit value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      drop_first_cfg = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic void check_field(string name, logic [VAR_W-1:0] want,
                                       logic [VAR_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation waiting");
            mismatch_count++;
         end else begin
            ora_pkg::result_type want;
            want = pending_results.pop_front();
            check_field("filtered_mean", VAR_W'(want.filtered_mean),
                        VAR_W'(rsp_filtered_mean));
            check_field("plain_mean", VAR_W'(want.plain_mean), VAR_W'(rsp_plain_mean));
            check_field("sample_variance", want.sample_variance, rsp_sample_variance);
            check_field("kept_count", VAR_W'(want.kept_count), VAR_W'(rsp_kept_count));
         end
      end
   end

   // result side: random stall bursts, calm stretches and one long hold-off
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (quiet_tail) begin
            rsp_stall <= 1'b0;
         end else begin
            n = $urandom_range(0, 19);
            if (n < 4) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 10) - 1) @(negedge clock);
            end else if (n == 4) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(20, 200) - 1) @(negedge clock);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // end the run as failed if it has not finished by the time limit
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      bit stored;
      int samples_stored;
      int phase;
      int len;
      int center;
      int spread;
      mix_type mode;

      samples_stored = 0;
      burst_fill = 0;
      drop_armed = 1'b1;
      drop_first_cfg = 1'b1;

      // extremes, discard on and off, and a register change inside a burst
      directed_rows = '{
         '{ROW_CFG,    12'd1,    1,  1'b0, 52'd0},
         '{ROW_SAMPLE, 12'd4095, 1,  1'b0, 52'd0},
         '{ROW_SAMPLE, 12'd0,    10, 1'b0, 52'd0},
         '{ROW_SAMPLE, 12'd4095, 10, 1'b1, {12'd0, 12'd2047, 23'd4192256, 5'd10}},
         '{ROW_CFG,    12'd0,    1,  1'b0, 52'd0},
         '{ROW_SAMPLE, 12'd4095, 20, 1'b1, {12'd4095, 12'd4095, 23'd0, 5'd20}},
         '{ROW_SAMPLE, 12'd0,    5,  1'b0, 52'd0},
         '{ROW_CFG,    12'd1,    1,  1'b0, 52'd0},
         '{ROW_SAMPLE, 12'd2048, 15, 1'b1, {12'd2048, 12'd1536, 23'd786432, 5'd15}},
         '{ROW_SAMPLE, 12'h555,  1,  1'b0, 52'd0}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the stimulus table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            settle_idle();
            write_discard(directed_rows[i].value[0]);
         end else begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
               send_sample(directed_rows[i].value,
                           directed_rows[i].has_exp && k == directed_rows[i].reps - 1,
                           directed_rows[i].exp, stored);
            end
         end
      end

      // random phases; the register may change between them, except in the tail
      phase = 0;
      while (samples_stored < RANDOM_SAMPLES) begin
         if (!quiet_tail) begin
            settle_idle();
            if ($urandom_range(0, 1) == 1) write_discard(1'($urandom_range(0, 1)));
         end
         mode = mix_type'($urandom_range(0, 3));
         center = $urandom_range(0, SAMPLE_MAX);
         spread = $urandom_range(0, 300);
         gap_rate = $urandom_range(0, 3);
         len = $urandom_range(5, 80);
         if (phase == 3) begin
            hold_request = 1'b1;
            gap_rate = 0;
            len = 60;
         end
         repeat (len) begin
            send_sample(draw_sample(mode, center, spread), 1'b0, '0, stored);
            if (stored) samples_stored++;
            quiet_tail = (samples_stored >= RANDOM_SAMPLES - TAIL_SAMPLES);
         end
         phase++;
      end

      settle_idle();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
